[hdl/crc_checked_frame_deframer_defines.svh]
// assertion macros for the crc checked frame deframer
// used by the top level only, no other dependencies
`ifndef CRC_CHECKED_FRAME_DEFRAMER_DEFINES_SVH
`define CRC_CHECKED_FRAME_DEFRAMER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CCFD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define CCFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/ccfd_pkg.sv]
// shared types, constants and crc step functions for the frame deframer
// no dependencies
`timescale 1ns / 1ps

package ccfd_pkg;

   localparam logic [7:0]  SOF_BYTE   = 8'hA5;
   localparam logic [7:0]  CRC8_INIT  = 8'hFF;
   localparam logic [7:0]  CRC8_POLY  = 8'h8C;
   localparam logic [15:0] CRC16_INIT = 16'hFFFF;
   localparam logic [15:0] CRC16_POLY = 16'h8408;
   localparam logic [15:0] MAX_LEN_RESET = 16'd512;

   localparam logic [2:0] ST_GOOD      = 3'd0;
   localparam logic [2:0] ST_HDR_BAD   = 3'd1;
   localparam logic [2:0] ST_TAIL_BAD  = 3'd2;
   localparam logic [2:0] ST_TOO_LONG  = 3'd3;
   localparam logic [2:0] ST_TRUNCATED = 3'd4;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_IDLE = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_HEAD = 3'd1,
      PH_CMD  = 3'd2,
      PH_DATA = 3'd3,
      PH_TAIL = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      CLS_BYTE = 2'd0,
      CLS_SOF  = 2'd1,
      CLS_IDLE = 2'd2
   } class_type;

   typedef struct packed {
      class_type  cls;
      logic [7:0] data;
   } entry_type;

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] x;
      x = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         x = x[0] ? ((x >> 1) ^ CRC8_POLY) : (x >> 1);
      end
      return x;
   endfunction

   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] t;
      t = {8'h00, crc[7:0] ^ b};
      for (int i = 0; i < 8; i++) begin
         t = t[0] ? ((t >> 1) ^ CRC16_POLY) : (t >> 1);
      end
      return {8'h00, crc[15:8]} ^ t;
   endfunction

endpackage

[hdl/ccfd_front.sv]
// front end: accepts request items, classifies them and pushes them to the queue
// depends on ccfd_pkg
`timescale 1ns / 1ps

module ccfd_front (
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_type,
   input  logic [7:0]           req_rx_byte,
   input  logic                 q_full,
   output logic                 q_push,
   output ccfd_pkg::entry_type  q_wdata
);

   ccfd_pkg::class_type cls;

   always_comb begin
      if (req_type == ccfd_pkg::REQ_IDLE) begin
         cls = ccfd_pkg::CLS_IDLE;
      end else if (req_rx_byte == ccfd_pkg::SOF_BYTE) begin
         cls = ccfd_pkg::CLS_SOF;
      end else begin
         cls = ccfd_pkg::CLS_BYTE;
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid & ~q_full;
   assign q_wdata   = {cls, req_rx_byte};

endmodule

[hdl/ccfd_queue.sv]
// short queue of classified items between front end and parser
// depends on ccfd_pkg
`timescale 1ns / 1ps

module ccfd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  ccfd_pkg::entry_type           wdata,
   input  logic                          pop,
   output ccfd_pkg::entry_type           rdata,
   output logic                          empty,
   output logic                          full,
   output logic [$clog2(DEPTH+1)-1:0]    level
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int LVL_W = $clog2(DEPTH + 1);

   ccfd_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             do_push, do_pop;

   assign empty   = (level_ff == '0);
   assign full    = (level_ff == LVL_W'(DEPTH));
   assign level   = level_ff;
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + LVL_W'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[hdl/ccfd_back.sv]
// back end: frame parser with crc8/crc16 checks and the result register
// depends on ccfd_pkg
`timescale 1ns / 1ps

module ccfd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data,
   input  logic                 q_empty,
   input  ccfd_pkg::entry_type  q_rdata,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_kind,
   output logic [7:0]           rsp_payload_byte,
   output logic [15:0]          rsp_byte_index,
   output logic [15:0]          rsp_command_id,
   output logic [15:0]          rsp_frame_length,
   output logic [7:0]           rsp_sequence_res,
   output logic [2:0]           rsp_status,
   output logic                 rsp_last
);

   ccfd_pkg::phase_type phase_ff, phase_in;
   logic [15:0] max_len_ff;
   logic [15:0] byte_count_ff, byte_count_in;
   logic [15:0] frame_len_ff, frame_len_in;
   logic [15:0] frame_cmd_ff, frame_cmd_in;
   logic [7:0]  frame_seq_ff, frame_seq_in;
   logic [7:0]  header_crc_ff, header_crc_in;
   logic [15:0] frame_crc_ff, frame_crc_in;
   logic        header_good_ff, header_good_in;
   logic [7:0]  tail_low_ff, tail_low_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff;
   logic [7:0]  rsp_byte_ff;
   logic [15:0] rsp_index_ff;
   logic [15:0] rsp_cmd_ff;
   logic [15:0] rsp_len_ff;
   logic [7:0]  rsp_seq_ff;
   logic [2:0]  rsp_status_ff;

   logic        emit;
   logic        res_kind;
   logic [7:0]  res_byte;
   logic [15:0] res_index;
   logic [2:0]  res_status;
   logic [7:0]  b;
   logic [15:0] crc16_next;
   logic [15:0] count_next;
   logic [15:0] rx_crc;

   assign q_pop      = ~q_empty & (~rsp_valid_ff | ~rsp_stall);
   assign b          = q_rdata.data;
   assign crc16_next = ccfd_pkg::crc16_step(frame_crc_ff, b);
   assign count_next = byte_count_ff + 16'd1;
   assign rx_crc     = {b, tail_low_ff};

   always_comb begin
      phase_in       = phase_ff;
      byte_count_in  = byte_count_ff;
      frame_len_in   = frame_len_ff;
      frame_cmd_in   = frame_cmd_ff;
      frame_seq_in   = frame_seq_ff;
      header_crc_in  = header_crc_ff;
      frame_crc_in   = frame_crc_ff;
      header_good_in = header_good_ff;
      tail_low_in    = tail_low_ff;
      emit           = 1'b0;
      res_kind       = ccfd_pkg::KIND_STATUS;
      res_byte       = 8'h00;
      res_index      = 16'h0000;
      res_status     = ccfd_pkg::ST_GOOD;
      if (q_pop) begin
         if (q_rdata.cls == ccfd_pkg::CLS_IDLE) begin
            if (phase_ff != ccfd_pkg::PH_HUNT) begin
               phase_in   = ccfd_pkg::PH_HUNT;
               emit       = 1'b1;
               res_status = ccfd_pkg::ST_TRUNCATED;
            end
         end else begin
            case (phase_ff)
               ccfd_pkg::PH_HEAD: begin
                  frame_crc_in = crc16_next;
                  if (byte_count_ff == 16'd1) begin
                     frame_len_in = {8'h00, b};
                  end else if (byte_count_ff == 16'd2) begin
                     frame_len_in = {b, frame_len_ff[7:0]};
                  end else if (byte_count_ff == 16'd3) begin
                     frame_seq_in = b;
                  end
                  if (byte_count_ff == 16'd1 || byte_count_ff == 16'd2 ||
                      byte_count_ff == 16'd3) begin
                     header_crc_in = ccfd_pkg::crc8_step(header_crc_ff, b);
                     byte_count_in = count_next;
                  end else begin
                     header_good_in = (b == header_crc_ff);
                     byte_count_in  = 16'd0;
                     if (frame_len_ff > max_len_ff) begin
                        phase_in   = ccfd_pkg::PH_HUNT;
                        emit       = 1'b1;
                        res_status = ccfd_pkg::ST_TOO_LONG;
                     end else begin
                        phase_in = ccfd_pkg::PH_CMD;
                     end
                  end
               end
               ccfd_pkg::PH_CMD: begin
                  frame_crc_in = crc16_next;
                  if (byte_count_ff == 16'd0) begin
                     frame_cmd_in  = {8'h00, b};
                     byte_count_in = 16'd1;
                  end else begin
                     frame_cmd_in  = {b, frame_cmd_ff[7:0]};
                     byte_count_in = 16'd0;
                     phase_in      = (frame_len_ff == 16'd0) ? ccfd_pkg::PH_TAIL
                                                             : ccfd_pkg::PH_DATA;
                  end
               end
               ccfd_pkg::PH_DATA: begin
                  frame_crc_in  = crc16_next;
                  byte_count_in = count_next;
                  if (count_next >= frame_len_ff) begin
                     byte_count_in = 16'd0;
                     phase_in      = ccfd_pkg::PH_TAIL;
                  end
                  if (header_good_ff) begin
                     emit      = 1'b1;
                     res_kind  = ccfd_pkg::KIND_DATA;
                     res_byte  = b;
                     res_index = byte_count_ff;
                  end
               end
               ccfd_pkg::PH_TAIL: begin
                  if (byte_count_ff == 16'd0) begin
                     tail_low_in   = b;
                     byte_count_in = 16'd1;
                  end else begin
                     byte_count_in = 16'd0;
                     phase_in      = ccfd_pkg::PH_HUNT;
                     emit          = 1'b1;
                     if (!header_good_ff) begin
                        res_status = ccfd_pkg::ST_HDR_BAD;
                     end else if (rx_crc != frame_crc_ff) begin
                        res_status = ccfd_pkg::ST_TAIL_BAD;
                     end else begin
                        res_status = ccfd_pkg::ST_GOOD;
                     end
                  end
               end
               default: begin
                  // hunting, unused codes included
                  phase_in = ccfd_pkg::PH_HUNT;
                  if (q_rdata.cls == ccfd_pkg::CLS_SOF) begin
                     frame_len_in   = 16'd0;
                     frame_cmd_in   = 16'd0;
                     frame_seq_in   = 8'd0;
                     header_good_in = 1'b0;
                     header_crc_in  = ccfd_pkg::crc8_step(ccfd_pkg::CRC8_INIT, b);
                     frame_crc_in   = ccfd_pkg::crc16_step(ccfd_pkg::CRC16_INIT, b);
                     byte_count_in  = 16'd1;
                     phase_in       = ccfd_pkg::PH_HEAD;
                  end
               end
            endcase
         end
      end
      rsp_valid_in = (q_pop & emit) | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= ccfd_pkg::PH_HUNT;
         max_len_ff     <= ccfd_pkg::MAX_LEN_RESET;
         byte_count_ff  <= 16'd0;
         frame_len_ff   <= 16'd0;
         frame_cmd_ff   <= 16'd0;
         frame_seq_ff   <= 8'd0;
         header_crc_ff  <= ccfd_pkg::CRC8_INIT;
         frame_crc_ff   <= ccfd_pkg::CRC16_INIT;
         header_good_ff <= 1'b0;
         tail_low_ff    <= 8'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         byte_count_ff  <= byte_count_in;
         frame_len_ff   <= frame_len_in;
         frame_cmd_ff   <= frame_cmd_in;
         frame_seq_ff   <= frame_seq_in;
         header_crc_ff  <= header_crc_in;
         frame_crc_ff   <= frame_crc_in;
         header_good_ff <= header_good_in;
         tail_low_ff    <= tail_low_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload, loaded only when a new result is produced
   always_ff @(posedge clock) begin
      if (q_pop && emit) begin
         rsp_kind_ff   <= res_kind;
         rsp_byte_ff   <= res_byte;
         rsp_index_ff  <= res_index;
         rsp_cmd_ff    <= frame_cmd_ff;
         rsp_len_ff    <= frame_len_ff;
         rsp_seq_ff    <= frame_seq_ff;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_payload_byte = rsp_byte_ff;
   assign rsp_byte_index   = rsp_index_ff;
   assign rsp_command_id   = rsp_cmd_ff;
   assign rsp_frame_length = rsp_len_ff;
   assign rsp_sequence_res = rsp_seq_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_kind_ff;

endmodule

[hdl/crc_checked_frame_deframer.sv]
// top level of the crc checked frame deframer
// depends on ccfd_pkg, ccfd_front, ccfd_queue, ccfd_back and the defines header
`timescale 1ns / 1ps
`include "crc_checked_frame_deframer_defines.svh"

// Takes one item per clock while the queue is not full: a received byte or a
// line-idle event. The parser does the crc8 and crc16 steps and the phase
// update together, so the sustained rate is one item per cycle while the
// result side does not stall. An item reaches the result port through the
// queue, then the result register. The queue of QUEUE_DEPTH items lets input
// keep flowing for that many items while the result side stalls. Each payload
// byte of a frame with a good header and in-range length gives one result;
// every frame gives one status result: at its tail, when too long or at idle.
// Write the maximum length register only while no frame is in flight.
module crc_checked_frame_deframer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_byte_index,
   output logic [15:0] rsp_command_id,
   output logic [15:0] rsp_frame_length,
   output logic [7:0]  rsp_sequence_res,
   output logic [2:0]  rsp_status,
   output logic        rsp_last
);

   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

   logic                q_push;
   logic                q_pop;
   logic                q_full;
   logic                q_empty;
   logic [LVL_W-1:0]    q_level;
   ccfd_pkg::entry_type q_wdata;
   ccfd_pkg::entry_type q_rdata;

   ccfd_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_type    (req_type),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_wdata     (q_wdata)
   );

   ccfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty),
      .full  (q_full),
      .level (q_level)
   );

   ccfd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .q_empty          (q_empty),
      .q_rdata          (q_rdata),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_command_id   (rsp_command_id),
      .rsp_frame_length (rsp_frame_length),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   `CCFD_ASSERT_IMPLY(a_level_bound, clock, reset, 1'b1, q_level <= LVL_W'(QUEUE_DEPTH), "queue level above depth")
   `CCFD_ASSERT_IMPLY(a_no_pop_stalled, clock, reset, rsp_valid && rsp_stall, !q_pop, "parser consumed an item while result stalled")
   `CCFD_ASSERT_IMPLY(a_data_status_good, clock, reset, rsp_valid && rsp_kind == ccfd_pkg::KIND_DATA, rsp_status == ccfd_pkg::ST_GOOD && !rsp_last, "payload result with status or last set")
   `CCFD_ASSERT_NEXT(a_level_grows, clock, reset, q_push && !q_pop, q_level == $past(q_level) + LVL_W'(1), "queue level did not grow on push")

endmodule
